[rtl/ovd_pkg.sv]
// ----------------------------------------------------------------------------
// ovd_pkg
// Shared constants, register map, config struct and ROM generators for the
// overdrive soft saturation waveshaper.
// ----------------------------------------------------------------------------
package ovd_pkg;

  localparam int DEFAULT_TABLE_BITS = 10;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] HPI_Q30 = 64'd1686629713;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_PREAMP_GAIN = 3'd1;
  localparam logic [2:0] REG_DRIVE       = 3'd2;
  localparam logic [2:0] REG_PHASE       = 3'd3;
  localparam logic [2:0] REG_SINE_GAIN   = 3'd4;

  localparam logic        RST_MODE        = 1'b1;
  localparam logic [15:0] RST_PREAMP_GAIN = 16'd4096;
  localparam logic [15:0] RST_DRIVE       = 16'd12288;
  localparam logic [15:0] RST_PHASE       = 16'd11433;
  localparam logic [23:0] RST_SINE_GAIN   = 24'd6374;

  localparam logic [15:0] DRIVE_MIN = 16'd4096;
  localparam logic [15:0] DRIVE_MAX = 16'd40960;

  localparam int NUM_STAGES = 12;

  typedef struct packed {
    logic        mode;
    logic [15:0] preamp_gain;
    logic [15:0] drive_amount;
    logic [15:0] sine_phase_scale;
    logic [23:0] sine_gain;
  } cfg_t;

  // log2 of a Q1.30 value in [1,2) as Q0.30, by repeated squaring
  function automatic logic [63:0] log2_frac(input logic [63:0] y);
    logic [63:0] m;
    logic [63:0] res;
    m   = y;
    res = '0;
    for (int k = 0; k < 30; k++) begin
      m   = (m * m) >> 30;
      res = res << 1;
      if (m >= (ONE_Q30 << 1)) begin
        m   = m >> 1;
        res = res | 64'd1;
      end
    end
    return res;
  endfunction

  // restoring shift-subtract quotient, used for ROM contents only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] log_rom_val(input int i, input int tb);
    if (i >= (1 << tb)) return ONE_Q30;
    return log2_frac(ONE_Q30 + (64'(i) << (30 - tb)));
  endfunction

  function automatic logic [63:0] exp_rom_val(input int i, input int tb);
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = ONE_Q30;
    hi = ONE_Q30 << 1;
    if (i >= (1 << tb)) return ONE_Q30 << 1;
    t = 64'(i) << (30 - tb);
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      if (log2_frac(mid) <= t) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [63:0] sin_rom_val(input int i, input int tb);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        dv;
    logic signed [63:0] sum;
    int                 ii;
    ii = (i > (1 << tb)) ? (1 << tb) : i;
    x    = (HPI_Q30 * 64'(ii)) >> tb;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 9; n++) begin
      dv   = 64'((2 * n) * (2 * n + 1));
      term = (term * x) >> 30;
      term = udiv((term * x) >> 30, dv);
      if ((n & 1) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    return sum;
  endfunction

endpackage

[rtl/overdrive_soft_saturation.sv]
// ----------------------------------------------------------------------------
// overdrive_soft_saturation
// Soft clipping waveshaper: Q1.23 sample in, shaped and saturated sample out.
// ----------------------------------------------------------------------------
// One sample enters per clock unless the output stalls. Holding out_stall_i
// while out_valid_o is high freezes the whole 12-stage shaping pipeline, and
// in_stall_o follows it. Registers are reached over APB at byte addresses 0x0
// mode, 0x4 preamp gain, 0x8 drive, 0xC sine phase scale, 0x10 sine gain, and
// should be written only while no sample is in flight.
module overdrive_soft_saturation #(
  parameter int TABLE_BITS = ovd_pkg::DEFAULT_TABLE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [23:0]         sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [23:0]         sample_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ovd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  ovd_pkg::cfg_t cfg_q;
  logic [ovd_pkg::NUM_STAGES-1:0] vld_q;
  logic       en;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign en      = !(vld_q[ovd_pkg::NUM_STAGES-1] && out_stall_i);
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode             <= ovd_pkg::RST_MODE;
      cfg_q.preamp_gain      <= ovd_pkg::RST_PREAMP_GAIN;
      cfg_q.drive_amount     <= ovd_pkg::RST_DRIVE;
      cfg_q.sine_phase_scale <= ovd_pkg::RST_PHASE;
      cfg_q.sine_gain        <= ovd_pkg::RST_SINE_GAIN;
    end else if (wr_en) begin
      case (reg_idx)
        ovd_pkg::REG_MODE:        cfg_q.mode             <= pwdata[0];
        ovd_pkg::REG_PREAMP_GAIN: cfg_q.preamp_gain      <= pwdata[15:0];
        ovd_pkg::REG_DRIVE:       cfg_q.drive_amount     <= pwdata[15:0];
        ovd_pkg::REG_PHASE:       cfg_q.sine_phase_scale <= pwdata[15:0];
        ovd_pkg::REG_SINE_GAIN:   cfg_q.sine_gain        <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ovd_pkg::REG_MODE:        prdata = {31'd0, cfg_q.mode};
      ovd_pkg::REG_PREAMP_GAIN: prdata = {16'd0, cfg_q.preamp_gain};
      ovd_pkg::REG_DRIVE:       prdata = {16'd0, cfg_q.drive_amount};
      ovd_pkg::REG_PHASE:       prdata = {16'd0, cfg_q.sine_phase_scale};
      ovd_pkg::REG_SINE_GAIN:   prdata = {8'd0, cfg_q.sine_gain};
      default:                  prdata = 32'd0;
    endcase
  end

  // valid bits ride alongside the datapath stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ovd_pkg::NUM_STAGES-2:0], in_valid_i};
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[ovd_pkg::NUM_STAGES-1];

  ovd_datapath #(
    .TABLE_BITS (TABLE_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .sample_i (sample_in_i),
    .sample_o (sample_out_o)
  );

endmodule

[rtl/ovd_datapath.sv]
// ----------------------------------------------------------------------------
// ovd_datapath
// Twelve-stage shaping pipeline: preamp gain, power curve via log2/exp2 ROMs,
// sine curve via quarter-wave ROM, rounding and saturation.
// ----------------------------------------------------------------------------
module ovd_datapath #(
  parameter int TABLE_BITS = ovd_pkg::DEFAULT_TABLE_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  ovd_pkg::cfg_t       cfg_i,
  input  logic signed [23:0]  sample_i,
  output logic signed [23:0]  sample_o
);

  localparam int N  = 1 << TABLE_BITS;
  localparam int FB = 30 - TABLE_BITS;
  localparam int K  = TABLE_BITS + 16;
  localparam logic [63:0] RECIP = (64'd1 << (31 + K)) / ovd_pkg::HPI_Q30;

  localparam logic [30:0] ONE31 = 31'(ovd_pkg::ONE_Q30);
  localparam logic [30:0] HPI31 = 31'(ovd_pkg::HPI_Q30);
  localparam logic [31:0] PI32  = 32'(ovd_pkg::PI_Q30);

  // ROMs
  logic [30:0] log_rom [0:N];
  logic [31:0] exp_rom [0:N];
  logic [30:0] sin_rom [0:N];

  for (genvar gi = 0; gi <= N; gi++) begin : g_rom
    localparam logic [63:0] LV = ovd_pkg::log_rom_val(gi, TABLE_BITS);
    localparam logic [63:0] EV = ovd_pkg::exp_rom_val(gi, TABLE_BITS);
    localparam logic [63:0] SV = ovd_pkg::sin_rom_val(gi, TABLE_BITS);
    assign log_rom[gi] = LV[30:0];
    assign exp_rom[gi] = EV[31:0];
    assign sin_rom[gi] = SV[30:0];
  end

  function automatic logic [4:0] msb_index(input logic [22:0] v);
    logic [4:0] e;
    e = '0;
    for (int b = 0; b < 23; b++) begin
      if (v[b]) e = 5'(b);
    end
    return e;
  endfunction

  // stage registers
  logic [39:0]           s1_prod_q;
  logic [11:1]           neg_q;
  logic [28:0]           s2_m_q;
  logic [29:0]           s3_f_q;
  logic [4:0]            s3_e_q, s4_e_q, s5_e_q;
  logic [9:3]            sat0_q, zero0_q;
  logic [31:0]           s3_ang_q;
  logic [11:3]           clip_q;
  logic [30:0]           s4_le0_q, s4_le1_q, s5_le0_q;
  logic [FB-1:0]         s4_fr_q;
  logic [30:0]           s4_t_q, s5_t_q, s6_t_q;
  logic [11:4]           sneg_q;
  logic [10:4]           force_q;
  logic [30+FB:0]        s5_lprod_q;
  logic [K+31:0]         s5_rprod_q;
  logic [34:0]           s6_n_q;
  logic [K:0]            s6_q0_q;
  logic [32:0]           s6_qh_q;
  logic [38:0]           s7_p_q;
  logic [TABLE_BITS:0]   s7_idx_q;
  logic [15:0]           s7_fr_q;
  logic [31:0]           s8_ee0_q, s8_ee1_q, s9_ee0_q;
  logic [FB-1:0]         s8_efr_q;
  logic [8:0]            s8_q_q, s9_q_q;
  logic                  s8_rz_q, s9_rz_q, s8_qbig_q, s9_qbig_q;
  logic [30:0]           s8_se0_q, s8_se1_q, s9_se0_q;
  logic [15:0]           s8_sfr_q;
  logic [31+FB:0]        s9_eprod_q;
  logic [46:0]           s9_sprod_q;
  logic [23:0]           s10_mag0_q, s11_mag0_q;
  logic [30:0]           s10_s_q;
  logic [54:0]           s11_sg_q;
  logic [23:0]           s11_cm_q;
  logic signed [23:0]    out_q;

  // combinational per-stage
  logic [23:0]           c1_mag;
  logic [40:0]           c2_sum;
  logic [22:0]           c3_v;
  logic [4:0]            c3_e;
  logic [30:0]           c3_sh;
  logic [39:0]           c3_aprod;
  logic [TABLE_BITS-1:0] c4_idx;
  logic [TABLE_BITS:0]   c4_idx1;
  logic [31:0]           c4_zq, c4_a, c4_t;
  logic                  c4_sneg, c4_force;
  logic [30:0]           c5_ldiff;
  logic [30:0]           c6_lg;
  logic [K:0]            c6_q0;
  logic [K+31:0]         c6_qh;
  logic [15:0]           c7_d;
  logic [50:0]           c7_np;
  logic [K+30:0]         c7_xs;
  logic [32:0]           c7_rem;
  logic [K:0]            c7_pos;
  logic [30:0]           c8_w;
  logic [TABLE_BITS-1:0] c8_eidx;
  logic [TABLE_BITS:0]   c8_eidx1, c8_sidx1;
  logic [31:0]           c9_ediff;
  logic [30:0]           c9_sdiff;
  logic [31:0]           c10_val, c10_pw;
  logic [31:0]           c10_sub;
  logic [30:0]           c11_smag;
  logic [31:0]           c11_cms;
  logic [55:0]           c12_rsum;
  logic [36:0]           c12_mag;
  logic                  c12_neg;

  always_comb begin
    c1_mag = sample_i[23] ? (~sample_i + 24'd1) : sample_i;

    c2_sum = {1'b0, s1_prod_q} + 41'd2048;

    c3_v     = 23'd0 - s2_m_q[22:0];
    c3_e     = msb_index(c3_v);
    c3_sh    = {8'd0, c3_v} << (5'd30 - c3_e);
    c3_aprod = s2_m_q[23:0] * cfg_i.sine_phase_scale;

    c4_idx  = s3_f_q[29:FB];
    c4_idx1 = {1'b0, c4_idx} + 1'b1;
    c4_zq   = {cfg_i.sine_phase_scale, 16'd0};
    c4_force = clip_q[3] && !((c4_zq > {1'b0, HPI31}) && (c4_zq < PI32));
    c4_a    = clip_q[3] ? c4_zq : s3_ang_q;
    c4_sneg = 1'b0;
    if (c4_a <= {1'b0, HPI31}) begin
      c4_t = c4_a;
    end else if (c4_a <= PI32) begin
      c4_t = PI32 - c4_a;
    end else begin
      c4_t    = c4_a - PI32;
      c4_sneg = 1'b1;
    end
    if (c4_t > {1'b0, HPI31}) c4_t = {1'b0, HPI31};

    c5_ldiff = (s4_le1_q < s4_le0_q) ? 31'd0 : (s4_le1_q - s4_le0_q);

    c6_lg = s5_le0_q + 31'(s5_lprod_q >> FB);
    c6_q0 = s5_rprod_q[K+31:31];
    c6_qh = c6_q0 * HPI31;

    if (cfg_i.drive_amount < ovd_pkg::DRIVE_MIN) c7_d = ovd_pkg::DRIVE_MIN;
    else if (cfg_i.drive_amount > ovd_pkg::DRIVE_MAX) c7_d = ovd_pkg::DRIVE_MAX;
    else c7_d = cfg_i.drive_amount;
    c7_np  = s6_n_q * c7_d;
    c7_xs  = {s6_t_q, {K{1'b0}}};
    c7_rem = c7_xs[32:0] - s6_qh_q;
    c7_pos = (c7_rem >= {2'd0, HPI31}) ? (s6_q0_q + 1'b1) : s6_q0_q;

    c8_w     = {1'b1, 30'd0} - {1'b0, s7_p_q[29:0]};
    c8_eidx  = c8_w[29:FB];
    c8_eidx1 = {1'b0, c8_eidx} + 1'b1;
    c8_sidx1 = (s7_idx_q == (TABLE_BITS + 1)'(N)) ? s7_idx_q : (s7_idx_q + 1'b1);

    c9_ediff = (s8_ee1_q < s8_ee0_q) ? 32'd0 : (s8_ee1_q - s8_ee0_q);
    c9_sdiff = (s8_se1_q < s8_se0_q) ? 31'd0 : (s8_se1_q - s8_se0_q);

    c10_val = s9_ee0_q + 32'(s9_eprod_q >> FB);
    if (s9_qbig_q) c10_pw = 32'd0;
    else if (s9_rz_q) c10_pw = {1'b0, ONE31} >> s9_q_q;
    else c10_pw = c10_val >> (s9_q_q + 9'd1);
    if (c10_pw > {1'b0, ONE31}) c10_pw = {1'b0, ONE31};
    c10_sub = ({1'b0, ONE31} - c10_pw) + 32'd64;

    c11_smag = force_q[10] ? ONE31 : s10_s_q;
    c11_cms  = {1'b0, c11_smag} + 32'd64;

    c12_rsum = {1'b0, s11_sg_q} + 56'd262144;
    if (!cfg_i.mode) c12_mag = {13'd0, s11_mag0_q};
    else if (clip_q[11]) c12_mag = {13'd0, s11_cm_q};
    else c12_mag = c12_rsum[55:19];
    c12_neg = cfg_i.mode ? (neg_q[11] ^ (sneg_q[11] && !clip_q[11])) : neg_q[11];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 1: preamp product
      s1_prod_q <= c1_mag * cfg_i.preamp_gain;
      neg_q[1]  <= sample_i[23];
      // 2: rounded gain
      s2_m_q   <= c2_sum[40:12];
      neg_q[2] <= neg_q[1];
      // 3: normalize 1-m, sine angle product
      s3_f_q     <= c3_sh[29:0];
      s3_e_q     <= c3_e;
      sat0_q[3]  <= s2_m_q >= 29'd8388608;
      zero0_q[3] <= s2_m_q == 29'd0;
      clip_q[3]  <= s2_m_q > 29'd8388608;
      s3_ang_q   <= c3_aprod[38:7];
      neg_q[3]   <= neg_q[2];
      // 4: log ROM, quadrant fold
      s4_le0_q   <= log_rom[{1'b0, c4_idx}];
      s4_le1_q   <= log_rom[c4_idx1];
      s4_fr_q    <= s3_f_q[FB-1:0];
      s4_e_q     <= s3_e_q;
      s4_t_q     <= c4_t[30:0];
      sneg_q[4]  <= c4_sneg;
      force_q[4] <= c4_force;
      // 5: log interp product, reciprocal product
      s5_lprod_q <= c5_ldiff * s4_fr_q;
      s5_le0_q   <= s4_le0_q;
      s5_e_q     <= s4_e_q;
      s5_rprod_q <= s4_t_q * RECIP[K:0];
      s5_t_q     <= s4_t_q;
      // 6: exponent argument n, quotient check product
      s6_n_q  <= {(5'd23 - s5_e_q), 30'd0} - {4'd0, c6_lg};
      s6_q0_q <= c6_q0;
      s6_qh_q <= c6_qh[32:0];
      s6_t_q  <= s5_t_q;
      // 7: n * drive, table position
      s7_p_q   <= c7_np[50:12];
      s7_idx_q <= c7_pos[K:16];
      s7_fr_q  <= c7_pos[15:0];
      // 8: exp and sine ROMs
      s8_ee0_q  <= exp_rom[{1'b0, c8_eidx}];
      s8_ee1_q  <= exp_rom[c8_eidx1];
      s8_efr_q  <= c8_w[FB-1:0];
      s8_q_q    <= s7_p_q[38:30];
      s8_rz_q   <= s7_p_q[29:0] == 30'd0;
      s8_qbig_q <= s7_p_q[38:30] >= 9'd40;
      s8_se0_q  <= sin_rom[s7_idx_q];
      s8_se1_q  <= sin_rom[c8_sidx1];
      s8_sfr_q  <= s7_fr_q;
      // 9: interp products
      s9_eprod_q <= c9_ediff * s8_efr_q;
      s9_ee0_q   <= s8_ee0_q;
      s9_q_q     <= s8_q_q;
      s9_rz_q    <= s8_rz_q;
      s9_qbig_q  <= s8_qbig_q;
      s9_sprod_q <= c9_sdiff * s8_sfr_q;
      s9_se0_q   <= s8_se0_q;
      // 10: power curve magnitude, sine value
      if (sat0_q[9]) s10_mag0_q <= 24'd8388608;
      else if (zero0_q[9]) s10_mag0_q <= 24'd0;
      else s10_mag0_q <= c10_sub[30:7];
      s10_s_q <= s9_se0_q + s9_sprod_q[46:16];
      // 11: output gain product, clip level
      s11_sg_q   <= s10_s_q * cfg_i.sine_gain;
      s11_cm_q   <= c11_cms[30:7];
      s11_mag0_q <= s10_mag0_q;
      // 12: sign and saturation
      if (c12_neg) begin
        out_q <= (c12_mag >= 37'd8388608) ? 24'sh800000 : (24'd0 - c12_mag[23:0]);
      end else begin
        out_q <= (c12_mag >= 37'd8388607) ? 24'sh7fffff : c12_mag[23:0];
      end
      // side-band carry
      neg_q[11:4]    <= neg_q[10:3];
      clip_q[11:4]   <= clip_q[10:3];
      sat0_q[9:4]    <= sat0_q[8:3];
      zero0_q[9:4]   <= zero0_q[8:3];
      sneg_q[11:5]   <= sneg_q[10:4];
      force_q[10:5]  <= force_q[9:4];
    end
  end

  assign sample_o = out_q;

endmodule

[sim/ovd_checker.sv]
// ----------------------------------------------------------------------------
// ovd_checker
// Watches the sample channels and the APB port of the waveshaper. Keeps its
// own register copy, predicts each shaped sample and compares every output
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ovd_checker #(
  parameter int TB = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [23:0]                sample_in_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [23:0]                sample_out_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [ovd_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output int                         pending_o,
  output int                         errors_o
);

  localparam int FB = 30 - TB;

  logic [63:0] lg_tab [0:(1<<TB)];
  logic [63:0] ex_tab [0:(1<<TB)];
  logic [63:0] sn_tab [0:(1<<TB)];

  ovd_pkg::cfg_t cfg;
  logic [23:0]   shaped_q[$];
  int            errors;

  assign pending_o = shaped_q.size();
  assign errors_o  = errors;

  function automatic logic [63:0] frac_log2(logic [63:0] y);
    logic [63:0] m;
    logic [63:0] res;
    m   = y;
    res = '0;
    repeat (30) begin
      m   = (m * m) >> 30;
      res = res << 1;
      if (m >= (ovd_pkg::ONE_Q30 << 1)) begin
        m      = m >> 1;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] taylor_sin(int i);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (ovd_pkg::HPI_Q30 * 64'(i)) >> TB;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 9; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = '0;
    if (acc > $signed(ovd_pkg::ONE_Q30)) acc = $signed(ovd_pkg::ONE_Q30);
    return acc;
  endfunction

  initial begin
    logic [63:0] lo, hi, mid, t;
    for (int i = 0; i <= (1 << TB); i++) begin
      sn_tab[i] = taylor_sin(i);
      if (i == (1 << TB)) begin
        lg_tab[i] = ovd_pkg::ONE_Q30;
        ex_tab[i] = ovd_pkg::ONE_Q30 << 1;
      end else begin
        lg_tab[i] = frac_log2(ovd_pkg::ONE_Q30 + (64'(i) << FB));
        t  = 64'(i) << FB;
        lo = ovd_pkg::ONE_Q30;
        hi = ovd_pkg::ONE_Q30 << 1;
        while (hi - lo > 1) begin
          mid = lo + ((hi - lo) >> 1);
          if (frac_log2(mid) <= t) lo = mid;
          else hi = mid;
        end
        ex_tab[i] = lo;
      end
    end
  end

  function automatic logic [63:0] lerp(logic [63:0] e0, logic [63:0] e1,
                                       logic [63:0] fr, int fb);
    if (e1 < e0) e1 = e0;
    return e0 + (((e1 - e0) * fr) >> fb);
  endfunction

  function automatic logic [63:0] tab_log2(logic [63:0] mant);
    logic [63:0] f;
    int          idx;
    f   = (mant - ovd_pkg::ONE_Q30) & (ovd_pkg::ONE_Q30 - 1);
    idx = int'(f >> FB);
    return lerp(lg_tab[idx], lg_tab[idx+1], f & ((64'd1 << FB) - 1), FB);
  endfunction

  function automatic logic [63:0] tab_exp2(logic [63:0] w);
    logic [63:0] f;
    int          idx;
    f   = w & (ovd_pkg::ONE_Q30 - 1);
    idx = int'(f >> FB);
    return lerp(ex_tab[idx], ex_tab[idx+1], f & ((64'd1 << FB) - 1), FB);
  endfunction

  function automatic logic [63:0] quarter_sin(logic [63:0] a);
    logic [63:0] pos;
    logic [63:0] e0;
    logic [63:0] e1;
    int          idx;
    if (a > ovd_pkg::HPI_Q30) a = ovd_pkg::HPI_Q30;
    pos = (a << (TB + 16)) / ovd_pkg::HPI_Q30;
    idx = int'(pos >> 16);
    e0  = sn_tab[idx];
    e1  = (idx >= (1 << TB)) ? e0 : sn_tab[idx+1];
    return lerp(e0, e1, pos & 64'hFFFF, 16);
  endfunction

  function automatic logic signed [63:0] wide_sin(logic [63:0] a);
    if (a <= ovd_pkg::HPI_Q30) return $signed(quarter_sin(a));
    if (a <= ovd_pkg::PI_Q30) return $signed(quarter_sin(ovd_pkg::PI_Q30 - a));
    return -$signed(quarter_sin(a - ovd_pkg::PI_Q30));
  endfunction

  function automatic logic [23:0] saturate(logic [63:0] mag, logic neg);
    logic signed [63:0] v;
    v = $signed((mag > (64'd1 << 40)) ? (64'd1 << 40) : mag);
    if (neg) v = -v;
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  function automatic logic [63:0] power_curve(logic [63:0] m);
    logic [63:0] v, mant, n, p, q, r, pw, d;
    int          e;
    if (m >= (64'd1 << 23)) return 64'd1 << 23;
    if (m == 0) return 0;
    v = (64'd1 << 23) - m;
    e = 22;
    while (e > 0 && !v[e]) e--;
    mant = v << (30 - e);
    n = (64'(23 - e) << 30) - tab_log2(mant);
    d = cfg.drive_amount < ovd_pkg::DRIVE_MIN ? 64'(ovd_pkg::DRIVE_MIN) :
        (cfg.drive_amount > ovd_pkg::DRIVE_MAX ? 64'(ovd_pkg::DRIVE_MAX) :
         64'(cfg.drive_amount));
    p = (n * d) >> 12;
    q = p >> 30;
    r = p & (ovd_pkg::ONE_Q30 - 1);
    if (q >= 40) pw = 0;
    else if (r == 0) pw = ovd_pkg::ONE_Q30 >> q;
    else pw = tab_exp2(ovd_pkg::ONE_Q30 - r) >> (q + 1);
    if (pw > ovd_pkg::ONE_Q30) pw = ovd_pkg::ONE_Q30;
    return ((ovd_pkg::ONE_Q30 - pw) + 64) >> 7;
  endfunction

  function automatic logic [23:0] shape_sample(logic [23:0] raw);
    logic               neg;
    logic               sneg;
    logic [63:0]        mag, m, smag, zq;
    logic signed [63:0] sv;
    neg = raw[23];
    mag = neg ? (64'h1000000 - 64'(raw)) : 64'(raw);
    m   = (mag * 64'(cfg.preamp_gain) + 2048) >> 12;
    if (!cfg.mode) return saturate(power_curve(m), neg);
    if (m > (64'd1 << 23)) begin
      // beyond full scale: clip-point value, or full scale outside (pi/2, pi)
      zq = 64'(cfg.sine_phase_scale) << 16;
      sv = $signed(ovd_pkg::ONE_Q30);
      if (zq > ovd_pkg::HPI_Q30 && zq < ovd_pkg::PI_Q30) sv = wide_sin(zq);
      sneg = sv < 0;
      smag = sneg ? -sv : sv;
      return saturate((smag + 64) >> 7, neg ^ sneg);
    end
    sv   = wide_sin((64'(cfg.sine_phase_scale) * m) >> 7);
    sneg = sv < 0;
    smag = sneg ? -sv : sv;
    return saturate((smag * 64'(cfg.sine_gain) + (64'd1 << 18)) >> 19, neg ^ sneg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [23:0] exp_val;
    if (!rst_ni) begin
      cfg <= '{ovd_pkg::RST_MODE, ovd_pkg::RST_PREAMP_GAIN, ovd_pkg::RST_DRIVE,
               ovd_pkg::RST_PHASE, ovd_pkg::RST_SINE_GAIN};
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          ovd_pkg::REG_MODE:        cfg.mode             <= pwdata_i[0];
          ovd_pkg::REG_PREAMP_GAIN: cfg.preamp_gain      <= pwdata_i[15:0];
          ovd_pkg::REG_DRIVE:       cfg.drive_amount     <= pwdata_i[15:0];
          ovd_pkg::REG_PHASE:       cfg.sine_phase_scale <= pwdata_i[15:0];
          ovd_pkg::REG_SINE_GAIN:   cfg.sine_gain        <= pwdata_i[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) shaped_q.push_back(shape_sample(sample_in_i));
      if (out_valid_i && !out_stall_i) begin
        if (shaped_q.size() == 0) begin
          $error("sample_out: unexpected transfer, actual %0d", $signed(sample_out_i));
          errors++;
        end else begin
          exp_val = shaped_q.pop_front();
          if (exp_val !== sample_out_i) begin
            $error("sample_out: expected %0d actual %0d", $signed(exp_val),
                   $signed(sample_out_i));
            errors++;
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule

[sim/tb_overdrive_soft_saturation.sv]
// ----------------------------------------------------------------------------
// tb_overdrive_soft_saturation
// Drives samples into the waveshaper under several register settings and
// traffic patterns; the checker predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tb_overdrive_soft_saturation;

  localparam int LIMIT = 600000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [23:0]          sample_in_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [23:0]          sample_out_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ovd_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  int pending;
  int errors;
  int cycles;
  int idle_pct;
  int stall_pct;

  overdrive_soft_saturation u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_in_i, .out_valid_o,
    .out_stall_i, .sample_out_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  ovd_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_i (sample_out_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_overdrive_soft_saturation: errors");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic md, logic [15:0] pg, logic [15:0] dr,
                           logic [15:0] ph, logic [23:0] sg);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    reg_write(ovd_pkg::REG_MODE, 32'(md));
    reg_write(ovd_pkg::REG_PREAMP_GAIN, 32'(pg));
    reg_write(ovd_pkg::REG_DRIVE, 32'(dr));
    reg_write(ovd_pkg::REG_PHASE, 32'(ph));
    reg_write(ovd_pkg::REG_SINE_GAIN, 32'(sg));
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(logic [23:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(4))
      0: return 24'($urandom_range(255)) ^ {24{$urandom_range(1) == 1}};
      1: return $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(4095))
                                  : 24'h800000 + 24'($urandom_range(4095));
      default: return 24'($urandom);
    endcase
  endfunction

  logic [23:0] edges [] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
                            24'h800000, 24'h800001, 24'h400000, 24'hC00000,
                            24'h555555, 24'hAAAAAA, 24'h100000, 24'hF00000};

  initial begin
    cycles      = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: sine shaping, unity gain
    foreach (edges[i]) send(edges[i]);
    configure(1'b0, 16'd4096, 16'd4096, ovd_pkg::RST_PHASE, ovd_pkg::RST_SINE_GAIN);
    foreach (edges[i]) send(edges[i]);
    configure(1'b0, 16'd65535, 16'd40960, ovd_pkg::RST_PHASE, ovd_pkg::RST_SINE_GAIN);
    foreach (edges[i]) send(edges[i]);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      case (ph)
        0: configure(1'b1, 16'd65535, 16'd0, 16'd51472, 24'hFFFFFF);
        1: configure(1'b1, 16'd0, 16'hFFFF, 16'd0, 24'd0);
        2: configure(1'b0, 16'd8192, 16'hFFFF, 16'd30000, 24'd9000);
        3: configure(1'b0, 16'd2048, 16'd0, 16'd20000, 24'd4096);
        default: configure(1'($urandom_range(1)), 16'($urandom),
                           16'($urandom_range(45000)), 16'($urandom_range(65535)),
                           24'($urandom_range(40000)));
      endcase
      for (int n = 0; n < 150; n++) begin
        if (ph == 5 && n == 75) begin
          in_valid_i <= 1'b0;
          wait (pending == 0);
          @(negedge clk_i);
        end
        send(rand_sample());
      end
    end

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (30) @(negedge clk_i);
    if (errors == 0) $display("tb_overdrive_soft_saturation: clean");
    else $display("tb_overdrive_soft_saturation: errors");
    $finish;
  end

endmodule

[overdrive_soft_saturation.f]
rtl/ovd_pkg.sv
rtl/ovd_datapath.sv
rtl/overdrive_soft_saturation.sv
sim/ovd_checker.sv
sim/tb_overdrive_soft_saturation.sv
